// File: rtl/fed_pkg.sv
// Shared constants for the feedback echo delay block.
package fed_pkg;

    // Gains are unsigned Q1.16, 65536 means 1.0.
    localparam int GAIN_W    = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    // APB register index, taken from paddr[2].
    localparam logic REG_RING_LENGTH = 1'b0;

endpackage

// File: rtl/feedback_echo_delay.sv
// Feedback echo over a ring buffer of signed fixed-point samples.
//
// Usage notes:
//   Input channel (sample_valid / sample_stall) carries one audio item per
//   cycle when not stalled: sample_in, delay_taps, feedback_gain, dry_gain and block_end.
//   Result channel (result_valid / result_stall) returns one item per input
//   item: sample_out and block_end_out, in input order.
//   ring_length is set through the APB port (byte address 0) while idle.
//   Throughput: one item per cycle unless result_stall holds the output.
//   The ring is a single memory with one registered read and one write per
//   cycle; the read for an item is issued in the input stage, its write-back
//   in the mix stage, with a bypass covering the entry written by the item
//   just ahead. Items go from the input register via stage B to the output.
//   Stall: while a result sits in the output register and result_stall is
//   high, the whole pipeline holds and sample_stall rises once the input
//   register is occupied. An empty input register still takes an item.
//   Reset: write position goes to 0, ring_length to RING_DEPTH. The ring is
//   not swept; a fill mark tracks the written prefix and entries beyond it
//   read as zero, so no clearing pass is needed and items are taken at once.
module feedback_echo_delay #(
    parameter int RING_DEPTH  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,

    // input items
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic [$clog2(RING_DEPTH)-1:0]       delay_taps,
    input  logic [fed_pkg::GAIN_W-1:0]          feedback_gain,
    input  logic [fed_pkg::GAIN_W-1:0]          dry_gain,
    input  logic                                block_end,

    // result items
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic                                block_end_out
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int S      = SAMPLE_BITS;
    localparam int P_W    = S + fed_pkg::GAIN_W + 1;   // gain * sample
    localparam int SUM_W  = S + 3;                     // two floored terms
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(64'sd1 <<< (S - 1)));
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(RING_DEPTH);

    // gain*a + (1-gain)*b, each product floored by the shift, sum saturated
    function automatic logic signed [S-1:0] mix(
        input logic [fed_pkg::GAIN_W-1:0] g,
        input logic signed [S-1:0]        a,
        input logic signed [S-1:0]        b
    );
        logic [fed_pkg::GAIN_W-1:0] gc;
        logic signed [P_W-1:0]      pa;
        logic signed [P_W-1:0]      pb;
        logic signed [SUM_W-1:0]    sum;
        gc  = fed_pkg::GAIN_ONE - g;
        pa  = $signed({1'b0, g}) * a;
        pb  = $signed({1'b0, gc}) * b;
        sum = $signed({pa[P_W-1], pa[P_W-1:fed_pkg::FRAC_BITS]})
            + $signed({pb[P_W-1], pb[P_W-1:fed_pkg::FRAC_BITS]});
        if (sum > SUM_MAX)
            mix = SUM_MAX[S-1:0];
        else if (sum < SUM_MIN)
            mix = SUM_MIN[S-1:0];
        else
            mix = sum[S-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] ring_len_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == fed_pkg::REG_RING_LENGTH);
    assign prdata    = (paddr[2] == fed_pkg::REG_RING_LENGTH) ? 32'(ring_len_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ring_len_reg <= DEPTH_LEN;
        else if (cfg_write)
            ring_len_reg <= pwdata[LEN_W-1:0];
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything moves together unless the output holds
    // ------------------------------------------------------------------
    logic a_vld_reg;
    logic b_vld_reg;
    logic o_vld_reg;
    logic run;
    logic accept;

    assign run          = !(o_vld_reg && result_stall);
    assign sample_stall = a_vld_reg && !run;
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = o_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                a_vld_reg <= 1'b1;
            else if (run)
                a_vld_reg <= 1'b0;
            if (run)
            begin
                b_vld_reg <= a_vld_reg;
                o_vld_reg <= b_vld_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register, address generation, ring read
    // ------------------------------------------------------------------
    logic signed [S-1:0]          a_x_reg;
    logic [ADDR_W-1:0]            a_delay_reg;
    logic [fed_pkg::GAIN_W-1:0]   a_fb_reg;
    logic [fed_pkg::GAIN_W-1:0]   a_dry_reg;
    logic                         a_mark_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg     <= sample_in;
            a_delay_reg <= delay_taps;
            a_fb_reg    <= feedback_gain;
            a_dry_reg   <= dry_gain;
            a_mark_reg  <= block_end;
        end
    end

    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [LEN_W-1:0]  hwm_reg;       // entries [0, hwm) have been written
    logic [LEN_W-1:0]  hwm_next;

    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  dly;
    logic [LEN_W-1:0]  wp_ext;
    logic [LEN_W-1:0]  wp_eff;
    logic [LEN_W-1:0]  rd_raw;
    logic [LEN_W-1:0]  rd;
    logic [LEN_W-1:0]  wp_inc;
    logic [fed_pkg::GAIN_W-1:0] fb_sat;
    logic [fed_pkg::GAIN_W-1:0] dry_sat;

    always_comb
    begin
        // zero length acts as one, oversize clips to the memory depth
        if (ring_len_reg == '0)
            len_a = LEN_W'(1);
        else if (ring_len_reg > DEPTH_LEN)
            len_a = DEPTH_LEN;
        else
            len_a = ring_len_reg;
        len_m1 = len_a - LEN_W'(1);
        dly    = (LEN_W'(a_delay_reg) > len_m1) ? len_m1 : LEN_W'(a_delay_reg);
        // position left outside a shrunk ring restarts at 0
        wp_ext = LEN_W'(wp_reg);
        wp_eff = (wp_ext >= len_a) ? '0 : wp_ext;
        rd_raw = (wp_eff >= dly) ? (wp_eff - dly) : (wp_eff + len_a - dly);
        rd     = (rd_raw >= len_a) ? '0 : rd_raw;
        wp_inc = wp_eff + LEN_W'(1);
        wp_next = (wp_inc >= len_a) ? '0 : wp_inc[ADDR_W-1:0];
        fb_sat  = (a_fb_reg  > fed_pkg::GAIN_ONE) ? fed_pkg::GAIN_ONE : a_fb_reg;
        dry_sat = (a_dry_reg > fed_pkg::GAIN_ONE) ? fed_pkg::GAIN_ONE : a_dry_reg;
    end

    // ------------------------------------------------------------------
    // Ring memory: registered read, write from stage B, read-old on a clash
    // ------------------------------------------------------------------
    logic signed [S-1:0] ring_mem [RING_DEPTH];
    logic signed [S-1:0] mem_q_reg;
    logic [ADDR_W-1:0]   b_wp_reg;
    logic signed [S-1:0] wdata;
    logic                ring_we;

    assign ring_we = run && b_vld_reg;

    always_ff @(posedge clk)
    begin
        if (run)
            mem_q_reg <= ring_mem[rd[ADDR_W-1:0]];
        if (ring_we)
            ring_mem[b_wp_reg] <= wdata;
    end

    // ------------------------------------------------------------------
    // Stage B: bypass select, mixing, write-back
    // ------------------------------------------------------------------
    logic signed [S-1:0]        b_x_reg;
    logic [fed_pkg::GAIN_W-1:0] b_fb_reg;
    logic [fed_pkg::GAIN_W-1:0] b_dry_reg;
    logic                       b_mark_reg;
    logic                       b_fwd_reg;     // ring entry came from item ahead
    logic signed [S-1:0]        b_fwd_data_reg;
    logic                       b_zero_reg;    // entry never written: reads zero
    logic signed [S-1:0]        delayed;
    logic signed [S-1:0]        y;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            b_x_reg        <= a_x_reg;
            b_fb_reg       <= fb_sat;
            b_dry_reg      <= dry_sat;
            b_mark_reg     <= a_mark_reg;
            b_wp_reg       <= wp_eff[ADDR_W-1:0];
            b_fwd_reg      <= b_vld_reg && (b_wp_reg == rd[ADDR_W-1:0]);
            b_fwd_data_reg <= wdata;
            b_zero_reg     <= (rd >= hwm_reg);
        end
    end

    always_comb
    begin
        if (b_fwd_reg)
            delayed = b_fwd_data_reg;
        else if (b_zero_reg)
            delayed = '0;
        else
            delayed = mem_q_reg;
        wdata = mix(b_fb_reg, delayed, b_x_reg);
        y     = mix(b_dry_reg, b_x_reg, delayed);
    end

    assign hwm_next = (ring_we && (LEN_W'(b_wp_reg) == hwm_reg)) ? (hwm_reg + LEN_W'(1))
                                                                 : hwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            hwm_reg <= '0;
        end
        else
        begin
            if (run && a_vld_reg)
                wp_reg <= wp_next;
            hwm_reg <= hwm_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [S-1:0] o_sample_reg;
    logic                o_mark_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            o_sample_reg <= y;
            o_mark_reg   <= b_mark_reg;
        end
    end

    assign sample_out    = o_sample_reg;
    assign block_end_out = o_mark_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= DEPTH_LEN)
        else $error("fill mark beyond ring depth");

    // the item in stage B has advanced the position but not yet written
    a_wp_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(wp_reg) <= (hwm_reg + LEN_W'(b_vld_reg)))
        else $error("write position ahead of filled prefix");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("input stalled without output backpressure");

    a_b_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (b_vld_reg && run) |=> result_valid)
        else $error("mixed item did not reach the output register");
`endif

endmodule
